>>> design/dbwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwt_pkg
// Shared types, codes and defaults of the dirty block write-back tracker.
// ----------------------------------------------------------------------------
package dbwt_pkg;

    localparam int ENTRY_COUNT_DEF = 64;
    localparam int WORD_WIDTH_DEF  = 64;
    localparam int CMDQ_DEPTH      = 2;

    localparam int OP_W     = 3;
    localparam int INDEX_W  = 6;
    localparam int DATA_W   = 64;
    localparam int SRC_W    = 3;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_LOAD     = 3'd0;
    localparam logic [OP_W-1:0] OP_UPDATE   = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE    = 3'd2;
    localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd3;
    localparam logic [OP_W-1:0] OP_DEQUEUE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    localparam logic [SRC_W-1:0] SRC_UNDEFINED = 3'd0;

    typedef enum logic [2:0] {
        KIND_LOAD,
        KIND_UPDATE,
        KIND_ERASE,
        KIND_RETRIEVE,
        KIND_DEQUEUE,
        KIND_BAD
    } t_kind;

    typedef struct packed {
        logic from_nv;
        logic enqueued;
        logic meta_dirty;
        logic data_dirty;
        logic valid;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

    typedef struct packed {
        t_kind                kind;
        logic [INDEX_W-1:0]   entry_index;
        logic [DATA_W-1:0]    data;
        logic [SRC_W-1:0]     source;
        logic                 use_nv;
        logic                 load_valid;
        logic                 load_crc_ok;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [INDEX_W-1:0]   index;
        logic [DATA_W-1:0]    data;
        logic [SRC_W-1:0]     source;
        logic                 valid;
        logic                 write_data;
    } t_result;

endpackage

>>> design/dbwt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwt_in_if
// Request channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface dbwt_in_if;
    import dbwt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [INDEX_W-1:0]  entry_index;
    logic [DATA_W-1:0]   data_in;
    logic [SRC_W-1:0]    source_in;
    logic                use_nv;
    logic                load_valid;
    logic                load_crc_ok;

    modport source (
        output valid, opcode, entry_index, data_in, source_in, use_nv,
               load_valid, load_crc_ok,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, data_in, source_in, use_nv,
               load_valid, load_crc_ok,
        output ready
    );
endinterface

>>> design/dbwt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwt_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface dbwt_out_if;
    import dbwt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [INDEX_W-1:0]   index_out;
    logic [DATA_W-1:0]    data_out;
    logic [SRC_W-1:0]     source_out;
    logic                 valid_out;
    logic                 write_data;

    modport source (
        output valid, status, index_out, data_out, source_out, valid_out, write_data,
        input  ready
    );

    modport sink (
        input  valid, status, index_out, data_out, source_out, valid_out, write_data,
        output ready
    );
endinterface

>>> design/dbwt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dbwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]          i_wr_data,
    input  logic                      i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]          o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> design/dbwt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwt_front
// Request intake: decodes the opcode, range-checks the entry index and
// pushes a classified command into the command queue.
// ----------------------------------------------------------------------------
module dbwt_front #(
    parameter int ENTRY_COUNT = dbwt_pkg::ENTRY_COUNT_DEF
) (
    dbwt_in_if.sink          i_in,
    input  logic             i_clearing,
    input  logic             i_q_full,
    output logic             o_push,
    output dbwt_pkg::t_cmd   o_cmd
);
    import dbwt_pkg::*;

    logic  out_of_range;
    t_kind kind;

    assign out_of_range = 32'(i_in.entry_index) >= 32'(ENTRY_COUNT);

    always_comb begin
        case (i_in.opcode)
            OP_LOAD:     kind = KIND_LOAD;
            OP_UPDATE:   kind = KIND_UPDATE;
            OP_ERASE:    kind = KIND_ERASE;
            OP_RETRIEVE: kind = KIND_RETRIEVE;
            OP_DEQUEUE:  kind = KIND_DEQUEUE;
            default:     kind = KIND_BAD;
        endcase
        // table operations on an entry past the end are refused
        if (i_in.opcode inside {[OP_LOAD:OP_RETRIEVE]} && out_of_range) begin
            kind = KIND_BAD;
        end
    end

    assign i_in.ready = !i_clearing && !i_q_full;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        o_cmd.kind        = kind;
        o_cmd.entry_index = i_in.entry_index;
        o_cmd.data        = i_in.data_in;
        o_cmd.source      = i_in.source_in;
        o_cmd.use_nv      = i_in.use_nv;
        o_cmd.load_valid  = i_in.load_valid;
        o_cmd.load_crc_ok = i_in.load_crc_ok;
    end
endmodule

>>> design/dbwt_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwt_cmd_queue
// Short command queue between the intake and the table engine.
// ----------------------------------------------------------------------------
module dbwt_cmd_queue #(
    parameter int DEPTH = dbwt_pkg::CMDQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dbwt_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output dbwt_pkg::t_cmd   o_cmd,
    output logic             o_empty,
    output logic             o_full
);
    import dbwt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("command queue read while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("command queue count lost a push");
endmodule

>>> design/dbwt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwt_back
// Table engine: read-modify-write of one entry per command, the write-back
// index FIFO, the reset clearing sweep and the result register.
// ----------------------------------------------------------------------------
module dbwt_back #(
    parameter int ENTRY_COUNT = dbwt_pkg::ENTRY_COUNT_DEF,
    parameter int WORD_WIDTH  = dbwt_pkg::WORD_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dbwt_pkg::t_cmd   i_cmd,
    input  logic             i_q_empty,
    output logic             o_pop,
    output logic             o_clearing,
    dbwt_out_if.source       o_out
);
    import dbwt_pkg::*;

    localparam int IDX_W = $clog2(ENTRY_COUNT);
    localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
    localparam int ENT_W = WORD_WIDTH + SRC_W + FLAGS_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_FIFO  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_clr_ptr;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_addr;
    logic               r_empty;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid;
    t_result            r_out;

    logic               ent_rd_en, ent_wr_en;
    logic [IDX_W-1:0]   ent_rd_addr, ent_wr_addr;
    logic [ENT_W-1:0]   ent_rd_data, ent_wr_data;
    logic               fifo_rd_en, fifo_wr_en;
    logic [IDX_W-1:0]   fifo_rd_data;

    logic [WORD_WIDTH-1:0] old_word, new_word, cmd_word;
    logic [SRC_W-1:0]      old_src, new_src;
    t_flags                old_flags, new_flags;
    t_result               res;
    logic                  ent_write, do_enq, do_deq, changed, enq_ok;
    logic                  commit, pop_deq;

    assign old_word  = ent_rd_data[ENT_W-1 -: WORD_WIDTH];
    assign old_src   = ent_rd_data[FLAGS_W +: SRC_W];
    assign old_flags = t_flags'(ent_rd_data[FLAGS_W-1:0]);
    assign cmd_word  = WORD_WIDTH'(r_cmd.data);

    assign commit  = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);
    assign o_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign pop_deq = o_pop && (i_cmd.kind == KIND_DEQUEUE);
    assign enq_ok  = !old_flags.enqueued && (r_count < CNT_W'(ENTRY_COUNT));

    assign o_clearing = (r_state == S_CLEAR);

    // per-command update of the entry and the result
    always_comb begin
        new_word  = old_word;
        new_src   = old_src;
        new_flags = old_flags;
        ent_write = 1'b0;
        do_enq    = 1'b0;
        do_deq    = 1'b0;
        changed   = 1'b0;
        res        = '0;
        res.status = ST_BAD;
        res.index  = r_cmd.entry_index;
        case (r_cmd.kind)
            KIND_LOAD: begin
                ent_write = 1'b1;
                if (r_cmd.load_crc_ok) begin
                    new_word = cmd_word;
                    new_src  = r_cmd.source;
                    if (r_cmd.load_valid) begin
                        new_flags.valid   = 1'b1;
                        new_flags.from_nv = 1'b1;
                    end else begin
                        new_flags.valid   = 1'b0;
                    end
                    res.status = ST_OK;
                end else begin
                    new_word          = '0;
                    new_src           = SRC_UNDEFINED;
                    new_flags.valid   = 1'b0;
                    new_flags.from_nv = 1'b0;
                    res.status        = ST_MISSING;
                end
                res.data   = DATA_W'(new_word);
                res.source = new_src;
                res.valid  = new_flags.valid;
            end
            KIND_UPDATE: begin
                ent_write            = 1'b1;
                new_flags.meta_dirty = 1'b1;
                new_src              = r_cmd.source;
                // a word that came from storage is always rewritten
                if (cmd_word != old_word || old_flags.from_nv) begin
                    new_flags.from_nv    = 1'b0;
                    new_word             = cmd_word;
                    new_flags.valid      = 1'b1;
                    new_flags.data_dirty = 1'b1;
                    res.status           = ST_OK;
                end else begin
                    res.status = ST_NO_CHANGE;
                end
                do_enq = enq_ok;
                if (enq_ok) begin
                    new_flags.enqueued = 1'b1;
                end
                res.data   = DATA_W'(new_word);
                res.source = new_src;
                res.valid  = new_flags.valid;
            end
            KIND_ERASE: begin
                ent_write = 1'b1;
                if (old_src != SRC_UNDEFINED) begin
                    new_src              = SRC_UNDEFINED;
                    new_flags.meta_dirty = 1'b1;
                    changed              = 1'b1;
                end
                if (old_flags.valid) begin
                    new_word             = '0;
                    new_flags.valid      = 1'b0;
                    new_flags.data_dirty = 1'b1;
                    new_flags.meta_dirty = 1'b1;
                    changed              = 1'b1;
                end
                if (changed) begin
                    do_enq = enq_ok;
                    if (enq_ok) begin
                        new_flags.enqueued = 1'b1;
                    end
                    res.status = ST_OK;
                end else begin
                    res.status = ST_NO_CHANGE;
                end
                res.data   = DATA_W'(new_word);
                res.source = new_src;
                res.valid  = new_flags.valid;
            end
            KIND_RETRIEVE: begin
                res.valid = old_flags.valid;
                if (!r_cmd.use_nv && old_flags.from_nv) begin
                    res.status = ST_BAD;
                end else if (old_flags.valid) begin
                    res.status = ST_OK;
                    res.data   = DATA_W'(old_word);
                    res.source = old_src;
                end else begin
                    res.status = ST_MISSING;
                end
            end
            KIND_DEQUEUE: begin
                if (r_empty) begin
                    res        = '0;
                    res.status = ST_EMPTY;
                end else begin
                    ent_write            = 1'b1;
                    do_deq               = 1'b1;
                    res.write_data       = old_flags.data_dirty;
                    new_flags.enqueued   = 1'b0;
                    new_flags.data_dirty = 1'b0;
                    new_flags.meta_dirty = 1'b0;
                    res.status           = ST_OK;
                    res.index            = INDEX_W'(r_addr);
                    res.data             = DATA_W'(old_word);
                    res.source           = old_src;
                    res.valid            = old_flags.valid;
                end
            end
            default: begin
            end
        endcase
    end

    // memory port control
    always_comb begin
        ent_rd_en   = (o_pop && (i_cmd.kind inside {KIND_LOAD, KIND_UPDATE,
                                                     KIND_ERASE, KIND_RETRIEVE}))
                      || (r_state == S_FIFO);
        ent_rd_addr = (r_state == S_FIFO) ? fifo_rd_data : IDX_W'(i_cmd.entry_index);
        ent_wr_en   = (r_state == S_CLEAR) || (commit && ent_write);
        ent_wr_addr = (r_state == S_CLEAR) ? r_clr_ptr : r_addr;
        ent_wr_data = (r_state == S_CLEAR) ? '0 : {new_word, new_src, new_flags};
        fifo_rd_en  = pop_deq && (r_count != '0);
        fifo_wr_en  = commit && do_enq;
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (commit && do_deq) begin
            n_head  = (r_head == IDX_W'(ENTRY_COUNT - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
        if (commit && do_enq) begin
            n_tail  = (r_tail == IDX_W'(ENTRY_COUNT - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_ptr   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_ptr <= r_clr_ptr + 1'b1;
                    if (r_clr_ptr == IDX_W'(ENTRY_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= fifo_rd_en ? S_FIFO : S_EXEC;
                    end
                end
                S_FIFO: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd   <= i_cmd;
            r_addr  <= IDX_W'(i_cmd.entry_index);
            r_empty <= (r_count == '0);
        end else if (r_state == S_FIFO) begin
            r_addr <= fifo_rd_data;
        end
        if (commit) begin
            r_out <= res;
        end
    end

    dbwt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRY_COUNT)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ent_wr_en),
        .i_wr_addr (ent_wr_addr),
        .i_wr_data (ent_wr_data),
        .i_rd_en   (ent_rd_en),
        .i_rd_addr (ent_rd_addr),
        .o_rd_data (ent_rd_data)
    );

    dbwt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ENTRY_COUNT)
    ) u_fifo_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fifo_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (r_addr),
        .i_rd_en   (fifo_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (fifo_rd_data)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out.status;
    assign o_out.index_out  = r_out.index;
    assign o_out.data_out   = r_out.data;
    assign o_out.source_out = r_out.source;
    assign o_out.valid_out  = r_out.valid;
    assign o_out.write_data = r_out.write_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRY_COUNT))
        else $error("write-back fifo count past table size");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("write-back fifo empty with head and tail apart");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && do_deq) |=> r_count == $past(r_count) - 1'b1)
        else $error("dequeue did not drop the fifo count");

    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && (r_cmd.kind == KIND_DEQUEUE) && r_empty)
        |-> (r_count == '0))
        else $error("fifo filled under an empty dequeue");
endmodule

>>> design/dirty_block_writeback_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_block_writeback_tracker_top
// Dirty entry table with a write-back index FIFO.
// Path: a request waits in the command queue, is popped in the idle state,
// read from the entry RAM (a dequeue that pops the FIFO reads the FIFO index
// first) and committed into the result register. The next command starts
// only once the last has committed, a pace set by the read-modify-write
// of the entry RAM through its registered read port. Reset: synchronous;
// after it a sweep zeroes each entry, the request channel held not ready.
// ----------------------------------------------------------------------------
module dirty_block_writeback_tracker_top #(
    parameter int ENTRY_COUNT = dbwt_pkg::ENTRY_COUNT_DEF,
    parameter int WORD_WIDTH  = dbwt_pkg::WORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbwt_in_if.sink     i_in,
    dbwt_out_if.source  o_out
);
    import dbwt_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push, pop, q_empty, q_full, clearing;

    dbwt_front #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_front (
        .i_in       (i_in),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    dbwt_cmd_queue #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dbwt_back #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_q_empty  (q_empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );
endmodule
